// ----- hdl/lcdinit_pkg.sv -----
package lcdinit_pkg;

  // Where the interpreter stands in the list.
  typedef enum logic [2:0] {
    PH_COUNT  = 3'd0,
    PH_OPCODE = 3'd1,
    PH_ARGCNT = 3'd2,
    PH_ARGS   = 3'd3,
    PH_DELAY  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DELAY = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    REG_DELAY_FLAG_MASK = 1'b0,
    REG_LONG_DELAY_MS   = 1'b1
  } reg_idx_t;

  localparam logic [7:0]  DELAY_CODE_LONG       = 8'd255;
  localparam logic [7:0]  DELAY_FLAG_MASK_RESET = 8'd128;
  localparam logic [15:0] LONG_DELAY_MS_RESET   = 16'd500;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] commands_left;
    logic [7:0] args_left;
    logic       delay_pending;
  } seq_state_t;

  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic [15:0] value;
    logic        list_end;
  } seq_result_t;

endpackage

// ----- hdl/lcdinit_step.sv -----
module lcdinit_step (
  input  lcdinit_pkg::seq_state_t  cur,
  input  logic [7:0]               list_byte,
  input  logic [7:0]               delay_flag_mask,
  input  logic [15:0]              long_delay_ms,
  output lcdinit_pkg::seq_state_t  nxt,
  output lcdinit_pkg::seq_result_t res
);

  logic [7:0] cmds_dec;
  logic       last_cmd;
  logic [7:0] argcnt;
  logic       want_delay;
  logic [7:0] args_dec;

  assign cmds_dec   = cur.commands_left - 8'd1;
  assign last_cmd   = (cmds_dec == 8'd0);
  assign argcnt     = list_byte & ~delay_flag_mask;
  assign want_delay = (list_byte & delay_flag_mask) != 8'd0;
  assign args_dec   = cur.args_left - 8'd1;

  always_comb begin
    nxt      = cur;
    res.emit = 1'b0;
    res.kind = lcdinit_pkg::KIND_CMD;
    res.value = {8'd0, list_byte};
    res.list_end = 1'b0;
    case (cur.phase)
      lcdinit_pkg::PH_OPCODE: begin
        res.emit  = 1'b1;
        nxt.phase = lcdinit_pkg::PH_ARGCNT;
      end
      lcdinit_pkg::PH_ARGCNT: begin
        nxt.delay_pending = want_delay;
        nxt.args_left     = argcnt;
        if (argcnt != 8'd0) begin
          nxt.phase = lcdinit_pkg::PH_ARGS;
        end else if (want_delay) begin
          nxt.phase = lcdinit_pkg::PH_DELAY;
        end else begin
          // A command with nothing to follow finishes here.
          nxt.commands_left = cmds_dec;
          nxt.phase = last_cmd ? lcdinit_pkg::PH_COUNT : lcdinit_pkg::PH_OPCODE;
          res.emit     = last_cmd;
          res.kind     = lcdinit_pkg::KIND_END;
          res.value    = 16'd0;
          res.list_end = last_cmd;
        end
      end
      lcdinit_pkg::PH_ARGS: begin
        nxt.args_left = args_dec;
        res.emit      = 1'b1;
        res.kind      = lcdinit_pkg::KIND_DATA;
        if (args_dec == 8'd0) begin
          if (cur.delay_pending) begin
            nxt.phase = lcdinit_pkg::PH_DELAY;
          end else begin
            nxt.commands_left = cmds_dec;
            nxt.phase = last_cmd ? lcdinit_pkg::PH_COUNT : lcdinit_pkg::PH_OPCODE;
            res.list_end = last_cmd;
          end
        end
      end
      lcdinit_pkg::PH_DELAY: begin
        nxt.delay_pending = 1'b0;
        nxt.commands_left = cmds_dec;
        nxt.phase = last_cmd ? lcdinit_pkg::PH_COUNT : lcdinit_pkg::PH_OPCODE;
        res.emit     = 1'b1;
        res.kind     = lcdinit_pkg::KIND_DELAY;
        res.value    = (list_byte == lcdinit_pkg::DELAY_CODE_LONG) ?
                       long_delay_ms : {8'd0, list_byte};
        res.list_end = last_cmd;
      end
      default: begin
        // Count byte; unused phase codes fall back here as well.
        nxt.commands_left = list_byte;
        nxt.args_left     = 8'd0;
        nxt.delay_pending = 1'b0;
        nxt.phase = (list_byte != 8'd0) ? lcdinit_pkg::PH_OPCODE : lcdinit_pkg::PH_COUNT;
      end
    endcase
  end

endmodule

// ----- hdl/lcd_init_command_list_sequencer_top.sv -----
// Each result word is registered: in the output register, or in the skid stage if held.
// Throughput: one list byte per cycle while not stalled; the per-byte phase update is a
// single combinational step between the sequencer state registers and the output register.
// A two-word output register with skid stage lets a byte be taken while a result waits.
// Reset (synchronous, active low) returns to expecting a count byte, empties the output
// and restores delay_flag_mask to 128 and long_delay_ms to 500.
module lcd_init_command_list_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_list_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_value,
  output logic        out_list_end
);

  logic [7:0]  delay_flag_mask_r;
  logic [15:0] long_delay_ms_r;

  lcdinit_pkg::seq_state_t  state_r;
  lcdinit_pkg::seq_state_t  state_nxt;
  lcdinit_pkg::seq_result_t step_res;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [15:0] out_value_r;
  logic        out_list_end_r;
  logic        skid_valid_r;
  logic [1:0]  skid_kind_r;
  logic [15:0] skid_value_r;
  logic        skid_list_end_r;

  logic in_acc;
  logic res_vld;
  logic out_free;

  lcdinit_step u_step (
    .cur             (state_r),
    .list_byte       (in_list_byte),
    .delay_flag_mask (delay_flag_mask_r),
    .long_delay_ms   (long_delay_ms_r),
    .nxt             (state_nxt),
    .res             (step_res)
  );

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign res_vld  = in_acc && step_res.emit;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_flag_mask_r <= lcdinit_pkg::DELAY_FLAG_MASK_RESET;
      long_delay_ms_r   <= lcdinit_pkg::LONG_DELAY_MS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lcdinit_pkg::REG_DELAY_FLAG_MASK: delay_flag_mask_r <= cfg_wdata[7:0];
        lcdinit_pkg::REG_LONG_DELAY_MS:   long_delay_ms_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= lcdinit_pkg::PH_COUNT;
      state_r.commands_left <= 8'd0;
      state_r.args_left     <= 8'd0;
      state_r.delay_pending <= 1'b0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // The skid stage only fills when the output word is held and a new result arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_vld;
      end
    end else if (res_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_kind_r     <= skid_kind_r;
        out_value_r    <= skid_value_r;
        out_list_end_r <= skid_list_end_r;
      end else if (res_vld) begin
        out_kind_r     <= step_res.kind;
        out_value_r    <= step_res.value;
        out_list_end_r <= step_res.list_end;
      end
    end else if (res_vld) begin
      skid_kind_r     <= step_res.kind;
      skid_value_r    <= step_res.value;
      skid_list_end_r <= step_res.list_end;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_value    = out_value_r;
  assign out_list_end = out_list_end_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without an output word");

  a_end_marker_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == lcdinit_pkg::KIND_END) |-> out_list_end_r)
    else $error("bare end marker without list_end");

  a_end_to_count: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && step_res.list_end) |=> (state_r.phase == lcdinit_pkg::PH_COUNT))
    else $error("list ended but count byte not expected next");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == lcdinit_pkg::PH_COUNT) |-> (state_r.commands_left == 8'd0))
    else $error("commands outstanding while expecting a count byte");

endmodule
